### design/sfd_pkg.sv
package sfd_pkg;

  localparam logic [10:0] ID_IGNORED = 11'h511;
  localparam logic [10:0] ID_BASE    = 11'h520;
  localparam logic [10:0] ID_FIRST   = 11'h521;
  localparam logic [10:0] ID_LAST    = 11'h528;

  localparam logic [1:0] CFG_WARMUP    = 2'd0;
  localparam logic [1:0] CFG_V2_THRESH = 2'd1;
  localparam logic [1:0] CFG_V3_FLOOR  = 2'd2;

  localparam logic [15:0] WARMUP_RESET    = 16'd150;
  localparam logic [30:0] V2_THRESH_RESET = 31'd3000;
  localparam logic [30:0] V3_FLOOR_RESET  = 31'd10000;

  localparam int MK_V  = 0;
  localparam int MK_V2 = 1;
  localparam int MK_V3 = 2;
  localparam int MK_V1 = 3;

  typedef enum logic [3:0] {
    QTY_IGNORED = 4'd0,
    QTY_CURRENT = 4'd1,
    QTY_VOLTAGE = 4'd2,
    QTY_VOLTAGE2 = 4'd3,
    QTY_VOLTAGE3 = 4'd4,
    QTY_TEMP    = 4'd5,
    QTY_POWER   = 4'd6,
    QTY_CHARGE  = 4'd7,
    QTY_ENERGY  = 4'd8,
    QTY_UNKNOWN = 4'd9
  } qty_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [63:0] payload_bytes;
  } in_item_t;

  typedef struct packed {
    qty_t               updated_quantity;
    logic signed [31:0] reading;
    logic signed [33:0] voltage1_mv;
    logic signed [31:0] low_mark;
    logic signed [31:0] high_mark;
    logic signed [33:0] voltage1_low;
    logic signed [33:0] voltage1_high;
    logic signed [63:0] charge_total;
    logic signed [63:0] energy_total;
    logic [31:0]        frames_seen;
  } result_t;

endpackage

### design/sfd_in_stage.sv
module sfd_in_stage import sfd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

### design/sfd_core.sv
module sfd_core import sfd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata,
  input  logic        fire,
  input  in_item_t    item,
  output result_t     result
);

  logic [15:0] warmup_r;
  logic [30:0] v2_thresh_r;
  logic [30:0] v3_floor_r;

  logic signed [31:0] v_now_r, v_now_nxt;
  logic signed [31:0] v2_now_r, v2_now_nxt;
  logic signed [31:0] v3_now_r, v3_now_nxt;
  logic signed [33:0] v1_now_r, v1_now_nxt;
  logic signed [33:0] low_r [4];
  logic signed [33:0] low_nxt [4];
  logic signed [33:0] high_r [4];
  logic signed [33:0] high_nxt [4];
  logic signed [31:0] last_chg_r, last_chg_nxt;
  logic signed [31:0] last_eng_r, last_eng_nxt;
  logic signed [63:0] chg_acc_r, chg_acc_nxt;
  logic signed [63:0] eng_acc_r, eng_acc_nxt;
  logic [31:0]        fc_r, fc_nxt;

  function automatic logic signed [33:0] sx34(input logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  function automatic logic signed [33:0] low_upd(input logic signed [33:0] old_v,
                                                 input logic signed [33:0] val,
                                                 input logic seed, input logic after,
                                                 input logic ok);
    logic signed [33:0] res;
    res = old_v;
    if (seed) begin
      res = val;
    end else if (after && ok && (val < old_v)) begin
      res = val;
    end
    return res;
  endfunction

  function automatic logic signed [33:0] high_upd(input logic signed [33:0] old_v,
                                                  input logic signed [33:0] val,
                                                  input logic after);
    return (after && (val > old_v)) ? val : old_v;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warmup_r    <= WARMUP_RESET;
      v2_thresh_r <= V2_THRESH_RESET;
      v3_floor_r  <= V3_FLOOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WARMUP:    warmup_r    <= cfg_wdata[15:0];
        CFG_V2_THRESH: v2_thresh_r <= cfg_wdata;
        CFG_V3_FLOOR:  v3_floor_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    logic signed [31:0] r;
    logic               meas;
    logic [10:0]        off;
    qty_t               q;
    logic [31:0]        fc_inc;
    logic               seed, after;
    logic signed [32:0] d33;
    logic signed [31:0] rd;
    logic signed [33:0] lo, hi;
    logic signed [32:0] c33;

    r       = item.payload_bytes[47:16];
    meas    = (item.frame_id >= ID_FIRST) && (item.frame_id <= ID_LAST);
    off     = item.frame_id - ID_BASE;
    fc_inc  = (fc_r == '1) ? fc_r : fc_r + 32'd1;
    seed    = fc_inc < {16'd0, warmup_r};
    after   = fc_inc > {16'd0, warmup_r};
    rd      = '0;
    lo      = '0;
    hi      = '0;

    v_now_nxt    = v_now_r;
    v2_now_nxt   = v2_now_r;
    v3_now_nxt   = v3_now_r;
    v1_now_nxt   = v1_now_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    last_chg_nxt = last_chg_r;
    last_eng_nxt = last_eng_r;
    chg_acc_nxt  = chg_acc_r;
    eng_acc_nxt  = eng_acc_r;
    fc_nxt       = fc_r;

    d33 = {r[31], r} - {v3_now_r[31], v3_now_r};
    c33 = '0;

    if (item.frame_id == ID_IGNORED) begin
      q = QTY_IGNORED;
    end else if (meas) begin
      q      = qty_t'(off[3:0]);
      fc_nxt = fc_inc;
      rd     = r;
      unique case (q)
        QTY_VOLTAGE: begin
          v_now_nxt  = r;
          v1_now_nxt = sx34(r) - (sx34(v2_now_r) + sx34(v3_now_r));
          low_nxt[MK_V]   = low_upd(low_r[MK_V], sx34(r), seed, after, 1'b1);
          high_nxt[MK_V]  = high_upd(high_r[MK_V], sx34(r), after);
          low_nxt[MK_V1]  = low_upd(low_r[MK_V1], v1_now_nxt, seed, after, 1'b1);
          high_nxt[MK_V1] = high_upd(high_r[MK_V1], v1_now_nxt, after);
          lo = low_nxt[MK_V];
          hi = high_nxt[MK_V];
        end
        QTY_VOLTAGE2: begin
          if ($signed({r[31], r}) > $signed({2'b00, v2_thresh_r})) begin
            if (d33[32] != d33[31]) begin
              rd = d33[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
              rd = d33[31:0];
            end
          end
          v2_now_nxt = rd;
          low_nxt[MK_V2]  = low_upd(low_r[MK_V2], sx34(rd), seed, after, 1'b1);
          high_nxt[MK_V2] = high_upd(high_r[MK_V2], sx34(rd), after);
          lo = low_nxt[MK_V2];
          hi = high_nxt[MK_V2];
        end
        QTY_VOLTAGE3: begin
          v3_now_nxt = r;
          low_nxt[MK_V3]  = low_upd(low_r[MK_V3], sx34(r), seed, after,
                                    $signed({r[31], r}) > $signed({2'b00, v3_floor_r}));
          high_nxt[MK_V3] = high_upd(high_r[MK_V3], sx34(r), after);
          lo = low_nxt[MK_V3];
          hi = high_nxt[MK_V3];
        end
        QTY_CHARGE: begin
          c33          = {r[31], r} - {last_chg_r[31], last_chg_r};
          chg_acc_nxt  = chg_acc_r + {{31{c33[32]}}, c33};
          last_chg_nxt = r;
        end
        QTY_ENERGY: begin
          c33          = {r[31], r} - {last_eng_r[31], last_eng_r};
          eng_acc_nxt  = eng_acc_r + {{31{c33[32]}}, c33};
          last_eng_nxt = r;
        end
        default: begin
        end
      endcase
    end else begin
      q = QTY_UNKNOWN;
    end

    result.updated_quantity = q;
    result.reading          = rd;
    result.voltage1_mv      = v1_now_nxt;
    result.low_mark         = lo[31:0];
    result.high_mark        = hi[31:0];
    result.voltage1_low     = low_nxt[MK_V1];
    result.voltage1_high    = high_nxt[MK_V1];
    result.charge_total     = chg_acc_nxt;
    result.energy_total     = eng_acc_nxt;
    result.frames_seen      = fc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_now_r    <= '0;
      v2_now_r   <= '0;
      v3_now_r   <= '0;
      v1_now_r   <= '0;
      for (int i = 0; i < 4; i++) begin
        low_r[i]  <= '0;
        high_r[i] <= '0;
      end
      last_chg_r <= '0;
      last_eng_r <= '0;
      chg_acc_r  <= '0;
      eng_acc_r  <= '0;
      fc_r       <= '0;
    end else if (fire) begin
      v_now_r    <= v_now_nxt;
      v2_now_r   <= v2_now_nxt;
      v3_now_r   <= v3_now_nxt;
      v1_now_r   <= v1_now_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      last_chg_r <= last_chg_nxt;
      last_eng_r <= last_eng_nxt;
      chg_acc_r  <= chg_acc_nxt;
      eng_acc_r  <= eng_acc_nxt;
      fc_r       <= fc_nxt;
    end
  end

endmodule

### design/sfd_out_stage.sv
module sfd_out_stage import sfd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  logic    valid_r, valid_nxt;
  result_t result_r;

  assign advance    = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_result = result_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

### design/shunt_frame_decoder_tracker_top.sv
// An item enters the input register; its result is then held in the output register.
// Throughput: one item per cycle; the input register, the single-pass tracker
// logic and the output register form a two-stage pipe that stalls only on out_tready.
// Reset (synchronous, rst_n low) empties both stages, clears all tracked values,
// marks, totals and the frame counter, and loads the register defaults.
module shunt_frame_decoder_tracker_top import sfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // payload_bytes
  input  logic [10:0]  in_tuser,   // frame_id
  output logic         out_tvalid,
  input  logic         out_tready,
  // reading, voltage1_mv, low_mark, high_mark, voltage1_low, voltage1_high,
  // charge_total, energy_total, frames_seen, two zero bits
  output logic [359:0] out_tdata,
  output logic [3:0]   out_tuser,  // updated_quantity
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_wdata
);

  in_item_t in_item, item;
  logic     item_valid, advance, fire;
  result_t  result, out_result;

  assign in_item.frame_id      = in_tuser;
  assign in_item.payload_bytes = in_tdata;
  assign fire = item_valid && advance;

  sfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sfd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (item),
    .result    (result)
  );

  sfd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tuser = out_result.updated_quantity;
  assign out_tdata = {2'b00,
                      out_result.frames_seen,
                      out_result.energy_total,
                      out_result.charge_total,
                      out_result.voltage1_high,
                      out_result.voltage1_low,
                      out_result.high_mark,
                      out_result.low_mark,
                      out_result.voltage1_mv,
                      out_result.reading};

endmodule
